// File: rtl/core/ugsow_pkg.sv
// Shared types, constants and the month table for the UTC to GPS
// second-of-week converter. No dependencies.
package ugsow_pkg;

    // Field widths of one request and one result
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int SOW_W    = 20;
    localparam int LEAP_W   = 8;

    // Internal widths
    localparam int DCOUNT_W = 20;   // days since epoch, up to about 773k
    localparam int TOD_W    = 17;   // hour*3600 + minute*60 + second
    localparam int MDAYS_W  = 9;    // days before month, up to 335
    localparam int QUART_W  = 10;   // year / 4
    localparam int CENT_W   = 6;    // year / 100
    localparam int LEAPS_W  = 10;   // leap days since epoch year

    localparam logic [YEAR_W-1:0]  EPOCH_YEAR    = 12'd1980;
    localparam logic [DAY_W-1:0]   EPOCH_DAY     = 5'd6;
    localparam logic [LEAP_W-1:0]  LEAP_RESET    = 8'd18;
    // Leap years in 1..1979
    localparam logic [LEAPS_W:0]   LEAPS_BEFORE  = 11'd479;
    // Reciprocal of 25 scaled by 1024
    localparam logic [5:0]         RECIP25       = 6'd41;
    localparam logic [QUART_W-1:0] QUART_PER_CENT = 10'd25;

    typedef struct packed {
        logic [SECOND_W-1:0] second;
        logic [MINUTE_W-1:0] minute;
        logic [HOUR_W-1:0]   hour;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
    } utc_in_t;

    // Between the day-count and the week-second sections
    typedef struct packed {
        logic [DCOUNT_W-1:0] day_count;
        logic [TOD_W-1:0]    tod;
        logic                before_epoch;
    } day_count_t;

    // Days before month m in a common year; m is already clamped to 1..12
    function automatic logic [MDAYS_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [MDAYS_W-1:0] d;
        unique case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// File: rtl/core/ugsow_day_count.sv
// Day-count section: three register stages that turn a UTC date into the
// day count since the GPS epoch and the seconds of the day. Uses ugsow_pkg.
module ugsow_day_count (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ugsow_pkg::utc_in_t    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ugsow_pkg::day_count_t out_data
);

    // ---------------- stage 1: clamp month, estimate quotients ----------------
    logic                            s1_valid_reg;
    logic                            s1_ready;
    logic [ugsow_pkg::YEAR_W-1:0]    s1_dy_reg;
    logic                            s1_before_reg;
    logic [ugsow_pkg::QUART_W-1:0]   s1_x1_reg;
    logic [ugsow_pkg::QUART_W-1:0]   s1_x2_reg;
    logic [ugsow_pkg::CENT_W-1:0]    s1_e1_reg;
    logic [ugsow_pkg::CENT_W-1:0]    s1_e2_reg;
    logic [ugsow_pkg::MDAYS_W-1:0]   s1_mdays_reg;
    logic                            s1_after_feb_reg;
    logic                            s1_y4z_reg;
    logic [ugsow_pkg::DAY_W-1:0]     s1_day_reg;
    logic [ugsow_pkg::HOUR_W-1:0]    s1_hour_reg;
    logic [ugsow_pkg::MINUTE_W-1:0]  s1_minute_reg;
    logic [ugsow_pkg::SECOND_W-1:0]  s1_second_reg;

    logic [ugsow_pkg::YEAR_W-1:0]    s1_ym1;
    logic [ugsow_pkg::QUART_W-1:0]   s1_x1;
    logic [ugsow_pkg::QUART_W-1:0]   s1_x2;
    logic [15:0]                     s1_p1;
    logic [15:0]                     s1_p2;
    logic [ugsow_pkg::MONTH_W-1:0]   s1_month;
    logic                            s1_before;

    // Quotients by 100 go through year/4 and a reciprocal of 25
    always_comb begin
        s1_ym1 = in_data.year - 12'd1;
        s1_x1  = s1_ym1[ugsow_pkg::YEAR_W-1:2];
        s1_x2  = in_data.year[ugsow_pkg::YEAR_W-1:2];
        s1_p1  = {6'd0, s1_x1} * {10'd0, ugsow_pkg::RECIP25};
        s1_p2  = {6'd0, s1_x2} * {10'd0, ugsow_pkg::RECIP25};
        if (in_data.month == 4'd0) begin
            s1_month = 4'd1;
        end else if (in_data.month > 4'd12) begin
            s1_month = 4'd12;
        end else begin
            s1_month = in_data.month;
        end
        // A year before the epoch, or a day before the sixth in January of the epoch year, gives a negative day count
        s1_before = (in_data.year < ugsow_pkg::EPOCH_YEAR)
                  || ((in_data.year == ugsow_pkg::EPOCH_YEAR) && (in_data.month <= 4'd1)
                      && (in_data.day < ugsow_pkg::EPOCH_DAY));
    end

    // ---------------- stage 2: exact quotients, leap count, time of day -------
    logic                            s2_valid_reg;
    logic                            s2_ready;
    logic [ugsow_pkg::YEAR_W-1:0]    s2_dy_reg;
    logic                            s2_before_reg;
    logic [ugsow_pkg::LEAPS_W-1:0]   s2_leaps_reg;
    logic [ugsow_pkg::MDAYS_W-1:0]   s2_mdays_reg;
    logic [ugsow_pkg::DAY_W-1:0]     s2_day_reg;
    logic [ugsow_pkg::TOD_W-1:0]     s2_tod_reg;

    logic [ugsow_pkg::QUART_W-1:0]   s2_r1;
    logic [ugsow_pkg::QUART_W-1:0]   s2_r2;
    logic [ugsow_pkg::CENT_W-1:0]    s2_q1;
    logic [ugsow_pkg::CENT_W-1:0]    s2_q2;
    logic                            s2_rem2_zero;
    logic                            s2_div100;
    logic                            s2_div400;
    logic                            s2_is_leap;
    logic [ugsow_pkg::LEAPS_W:0]     s2_leaps;
    logic [ugsow_pkg::TOD_W-1:0]     s2_tod;

    always_comb begin
        // Correct the reciprocal estimate by at most one
        s2_r1 = s1_x1_reg - ({4'd0, s1_e1_reg} * ugsow_pkg::QUART_PER_CENT);
        s2_r2 = s1_x2_reg - ({4'd0, s1_e2_reg} * ugsow_pkg::QUART_PER_CENT);
        s2_q1 = s1_e1_reg + {5'd0, (s2_r1 >= ugsow_pkg::QUART_PER_CENT)};
        s2_q2 = s1_e2_reg + {5'd0, (s2_r2 >= ugsow_pkg::QUART_PER_CENT)};
        s2_rem2_zero = (s2_r2 == 10'd0) || (s2_r2 == ugsow_pkg::QUART_PER_CENT);
        s2_div100  = s1_y4z_reg && s2_rem2_zero;
        s2_div400  = s2_div100 && (s2_q2[1:0] == 2'd0);
        s2_is_leap = (s1_y4z_reg && !s2_div100) || s2_div400;
        // Leap years in 1980..year-1
        s2_leaps = {1'b0, s1_x1_reg} - {5'd0, s2_q1} + {7'd0, s2_q1[5:2]}
                 - ugsow_pkg::LEAPS_BEFORE;
        s2_tod = ({12'd0, s1_hour_reg} * 17'd3600)
               + ({11'd0, s1_minute_reg} * 17'd60)
               + {11'd0, s1_second_reg};
    end

    // ---------------- stage 3: sum the day count -------------------------------
    logic                            s3_valid_reg;
    logic                            s3_ready;
    logic [ugsow_pkg::DCOUNT_W-1:0]  s3_count_reg;
    logic [ugsow_pkg::TOD_W-1:0]     s3_tod_reg;
    logic                            s3_before_reg;
    logic [ugsow_pkg::DCOUNT_W:0]    s3_count;

    always_comb begin
        s3_count = ({9'd0, s2_dy_reg} * 21'd365)
                 + {11'd0, s2_leaps_reg}
                 + {12'd0, s2_mdays_reg}
                 + {16'd0, s2_day_reg}
                 - {16'd0, ugsow_pkg::EPOCH_DAY};
    end

    // Each stage takes a new request when it is empty or its successor moves
    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) s1_valid_reg <= in_valid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
        end
    end

    // Load payload of each stage
    always_ff @(posedge aclk) begin
        if (s1_ready && in_valid) begin
            s1_dy_reg        <= in_data.year - ugsow_pkg::EPOCH_YEAR;
            s1_before_reg    <= s1_before;
            s1_x1_reg        <= s1_x1;
            s1_x2_reg        <= s1_x2;
            s1_e1_reg        <= s1_p1[15:10];
            s1_e2_reg        <= s1_p2[15:10];
            s1_mdays_reg     <= ugsow_pkg::days_before_month(s1_month);
            s1_after_feb_reg <= (s1_month > 4'd2);
            s1_y4z_reg       <= (in_data.year[1:0] == 2'd0);
            s1_day_reg       <= in_data.day;
            s1_hour_reg      <= in_data.hour;
            s1_minute_reg    <= in_data.minute;
            s1_second_reg    <= in_data.second;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_dy_reg     <= s1_dy_reg;
            s2_before_reg <= s1_before_reg;
            s2_leaps_reg  <= s2_leaps[ugsow_pkg::LEAPS_W-1:0];
            s2_mdays_reg  <= s1_mdays_reg + {8'd0, (s1_after_feb_reg && s2_is_leap)};
            s2_day_reg    <= s1_day_reg;
            s2_tod_reg    <= s2_tod;
        end
        if (s3_ready && s2_valid_reg) begin
            s3_count_reg  <= s3_count[ugsow_pkg::DCOUNT_W-1:0];
            s3_tod_reg    <= s2_tod_reg;
            s3_before_reg <= s2_before_reg;
        end
    end

    assign out_valid              = s3_valid_reg;
    assign out_data.day_count     = s3_count_reg;
    assign out_data.tod           = s3_tod_reg;
    assign out_data.before_epoch  = s3_before_reg;

endmodule

// File: rtl/core/ugsow_week_sec.sv
// Week-second section: day of week by octal digit folding, then the final
// seconds sum in the output register. Uses ugsow_pkg.
module ugsow_week_sec (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ugsow_pkg::LEAP_W-1:0]  leap_offset,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  ugsow_pkg::day_count_t         in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ugsow_pkg::SOW_W-1:0]   out_sow,
    output logic                          out_before
);

    // ---------------- stage 4: day count modulo 7 ------------------------------
    logic                          s4_valid_reg;
    logic                          s4_ready;
    logic [2:0]                    s4_dow_reg;
    logic [ugsow_pkg::TOD_W-1:0]   s4_tod_reg;
    logic                          s4_before_reg;

    logic [5:0] s4_sum1;
    logic [3:0] s4_sum2;
    logic [3:0] s4_sum3;
    logic [2:0] s4_dow;

    // 8 is 1 modulo 7, so the octal digits sum to the same residue
    always_comb begin
        s4_sum1 = {3'd0, in_data.day_count[2:0]}   + {3'd0, in_data.day_count[5:3]}
                + {3'd0, in_data.day_count[8:6]}   + {3'd0, in_data.day_count[11:9]}
                + {3'd0, in_data.day_count[14:12]} + {3'd0, in_data.day_count[17:15]}
                + {4'd0, in_data.day_count[19:18]};
        s4_sum2 = {1'b0, s4_sum1[2:0]} + {1'b0, s4_sum1[5:3]};
        s4_sum3 = {1'b0, s4_sum2[2:0]} + {3'd0, s4_sum2[3]};
        s4_dow  = (s4_sum3 >= 4'd7) ? 3'(s4_sum3 - 4'd7) : s4_sum3[2:0];
    end

    // ---------------- stage 5: seconds of week, output register ----------------
    logic                          s5_valid_reg;
    logic                          s5_ready;
    logic [ugsow_pkg::SOW_W-1:0]   s5_sow_reg;
    logic                          s5_before_reg;
    logic [ugsow_pkg::SOW_W-1:0]   s5_sow;

    always_comb begin
        s5_sow = ({17'd0, s4_dow_reg} * 20'd86400)
               + {3'd0, s4_tod_reg}
               + {12'd0, leap_offset};
    end

    assign s5_ready = !s5_valid_reg || out_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign in_ready = s4_ready;

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else begin
            if (s4_ready) s4_valid_reg <= in_valid;
            if (s5_ready) s5_valid_reg <= s4_valid_reg;
        end
    end

    // Load payload; a date before the epoch gives a zero result
    always_ff @(posedge aclk) begin
        if (s4_ready && in_valid) begin
            s4_dow_reg    <= s4_dow;
            s4_tod_reg    <= in_data.tod;
            s4_before_reg <= in_data.before_epoch;
        end
        if (s5_ready && s4_valid_reg) begin
            s5_sow_reg    <= s4_before_reg ? '0 : s5_sow;
            s5_before_reg <= s4_before_reg;
        end
    end

    assign out_valid  = s5_valid_reg;
    assign out_sow    = s5_sow_reg;
    assign out_before = s5_before_reg;

endmodule

// File: rtl/core/utc_to_gps_second_of_week.sv
// UTC to GPS second of week: five register stages, leap offset register.
// Throughput: one request per cycle; each stage moves whenever the next is
// empty or moving, so back pressure stalls without loss or repetition.
// Reset (aresetn low, synchronous): all stages empty, offset back to 18.
// Depends on ugsow_pkg, ugsow_day_count and ugsow_week_sec.
module utc_to_gps_second_of_week (
    input  logic        aclk,
    input  logic        aresetn,
    // year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26],
    // second[37:32], zero fill [39:38]
    input  logic [39:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // second_of_week[19:0], zero fill [23:20]
    output logic [23:0] m_tdata,
    // before_epoch[0]
    output logic [0:0]  m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // leap_second_offset[7:0]
    input  logic [7:0]  cfg_data,
    input  logic        cfg_valid,
    output logic        cfg_ready
);

    logic [ugsow_pkg::LEAP_W-1:0] leap_offset_reg;
    ugsow_pkg::utc_in_t           in_item;
    ugsow_pkg::day_count_t        dc_data;
    logic                         dc_valid;
    logic                         dc_ready;
    logic [ugsow_pkg::SOW_W-1:0]  sow;
    logic                         before_epoch;

    // Hold the leap second offset
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            leap_offset_reg <= ugsow_pkg::LEAP_RESET;
        end else if (cfg_valid) begin
            leap_offset_reg <= cfg_data;
        end
    end

    // Unpack the request
    assign in_item = ugsow_pkg::utc_in_t'(s_tdata[37:0]);

    ugsow_day_count u_day_count (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (in_item),
        .out_valid (dc_valid),
        .out_ready (dc_ready),
        .out_data  (dc_data)
    );

    ugsow_week_sec u_week_sec (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .leap_offset (leap_offset_reg),
        .in_valid    (dc_valid),
        .in_ready    (dc_ready),
        .in_data     (dc_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_sow     (sow),
        .out_before  (before_epoch)
    );

    assign m_tdata = {4'd0, sow};
    assign m_tuser = before_epoch;

`ifndef ASSERT_OFF
    // A date before the epoch always carries a zero result
    a_before_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[19:0] == 20'd0))
        else $error("before_epoch result is not zero");

    // Input stalls only under output back pressure with a full pipeline
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output back pressure");

    // A configuration write lands in the offset register
    a_cfg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready) |=> (leap_offset_reg == $past(cfg_data)))
        else $error("leap offset write lost");

    // Output payload holds while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");
`endif

endmodule

// File: tb/utc_to_gps_second_of_week_tb.sv
// Self-checking testbench for utc_to_gps_second_of_week: directed dates, then
// random requests under several idle and stall mixes and leap offsets.
// Depends on ugsow_pkg and the converter RTL.
`timescale 1ns / 100ps

module utc_to_gps_second_of_week_tb;

    localparam int PIPE_LAT      = 5;     // request accept to m_tvalid
    localparam int SETTLE_CYCLES = 2 * PIPE_LAT + 4;
    localparam int STALL_LIMIT   = 4000;  // cycles with no handshake at all
    localparam int ITEMS_PER_MIX = 150;

    typedef struct packed {
        logic [ugsow_pkg::SOW_W-1:0] sow;
        logic                        before_epoch;
    } tow_result_t;

    typedef struct {
        ugsow_pkg::utc_in_t req;
        bit                 typed;
        tow_result_t        res;
    } date_case_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic [39:0]                  s_tdata = '0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [23:0]                  m_tdata;
    logic [0:0]                   m_tuser;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [ugsow_pkg::LEAP_W-1:0] cfg_data = '0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;

    tow_result_t                  pending_tow [$];
    date_case_t                   date_cases [$];
    logic [ugsow_pkg::LEAP_W-1:0] leap_ofs = ugsow_pkg::LEAP_RESET;
    int                           sender_idle_pct = 0;
    int                           recv_stall_pct = 0;
    int                           err_count = 0;
    int                           sent_count = 0;
    int                           checked_count = 0;
    int                           pre_epoch_count = 0;
    int                           quiet_cycles = 0;

    utc_to_gps_second_of_week dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    always #1 aclk = ~aclk;

    function automatic int month_len(int m, bit leap);
        case (m)
            4, 6, 9, 11: return 30;
            2:           return leap ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    // Compute the GPS second of week for one request under the given offset
    function automatic tow_result_t predict_tow(ugsow_pkg::utc_in_t req,
                                                logic [ugsow_pkg::LEAP_W-1:0] ofs);
        tow_result_t res;
        int          y;
        int          m;
        int          days;
        int          k;
        bit          leap;
        res.sow = '0;
        res.before_epoch = 1'b1;
        y = int'(req.year);
        if (y < 1980)
            return res;
        m = int'(req.month);
        if (m == 0)
            m = 1;
        if (m > 12)
            m = 12;
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        // whole years, then whole months, then the day itself
        days = 365 * (y - 1980) + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400
             - (1979 / 4 - 1979 / 100 + 1979 / 400);
        for (k = 1; k < m; k++)
            days += month_len(k, leap);
        days = days + int'(req.day) - 6;
        if (days < 0)
            return res;
        res.before_epoch = 1'b0;
        res.sow = 20'((days % 7) * 86400 + int'(req.hour) * 3600 + int'(req.minute) * 60
                      + int'(req.second) + int'(ofs));
        return res;
    endfunction

    function automatic date_case_t date_case(int y, int mo, int d, int h, int mi, int s,
                                             bit typed, int sow, bit be);
        date_case_t c;
        c.req.year   = 12'(y);
        c.req.month  = 4'(mo);
        c.req.day    = 5'(d);
        c.req.hour   = 5'(h);
        c.req.minute = 6'(mi);
        c.req.second = 6'(s);
        c.typed = typed;
        c.res.sow = 20'(sow);
        c.res.before_epoch = be;
        return c;
    endfunction

    // Mostly valid calendar dates, the rest raw field noise
    function automatic ugsow_pkg::utc_in_t random_utc();
        ugsow_pkg::utc_in_t r;
        logic [63:0]        raw;
        int                 y;
        bit                 leap;
        if ($urandom_range(99) < 20) begin
            raw = {$urandom, $urandom};
            r = raw[$bits(ugsow_pkg::utc_in_t)-1:0];
            return r;
        end
        if ($urandom_range(9) == 0) begin
            // hug the epoch boundary
            y = 1980;
            r.month = 4'd1;
            r.day = 5'($urandom_range(1, 12));
        end else begin
            y = $urandom_range(1980, 2235);
            leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
            r.month = 4'($urandom_range(1, 12));
            r.day = 5'($urandom_range(1, month_len(int'(r.month), leap)));
        end
        r.year = 12'(y);
        r.hour = 5'($urandom_range(0, 23));
        r.minute = 6'($urandom_range(0, 59));
        r.second = 6'($urandom_range(0, 60));
        return r;
    endfunction

    // Offer one request, idling first at random; record what it must produce
    task automatic send_date(ugsow_pkg::utc_in_t req, bit typed, tow_result_t typed_res);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, req};
        do @(posedge aclk); while (!s_tready);
        pending_tow.push_back(typed ? typed_res : predict_tow(req, leap_ofs));
        sent_count++;
    endtask

    // Hold off new requests until every expected result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_tow.size() != 0)
            @(posedge aclk);
        repeat (PIPE_LAT) @(posedge aclk);
    endtask

    task automatic write_leap_offset(logic [ugsow_pkg::LEAP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        leap_ofs = value;
    endtask

    // Randomize receiver back pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check each result against the oldest expectation
    always @(posedge aclk) begin
        tow_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_tow.size() == 0) begin
                $display("%0t: unexpected result sow=%0d before_epoch=%0b",
                         $time, m_tdata[ugsow_pkg::SOW_W-1:0], m_tuser[0]);
                err_count++;
            end else begin
                exp_res = pending_tow.pop_front();
                checked_count++;
                if (exp_res.before_epoch)
                    pre_epoch_count++;
                if (m_tdata[ugsow_pkg::SOW_W-1:0] !== exp_res.sow) begin
                    $display("%0t: second_of_week expected %0d, got %0d",
                             $time, exp_res.sow, m_tdata[ugsow_pkg::SOW_W-1:0]);
                    err_count++;
                end
                if (m_tuser[0] !== exp_res.before_epoch) begin
                    $display("%0t: before_epoch expected %0b, got %0b",
                             $time, exp_res.before_epoch, m_tuser[0]);
                    err_count++;
                end
            end
        end
    end

    // Abort when no handshake happens for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, pending_tow.size());
            $display("utc_to_gps_second_of_week_tb failed");
            $finish;
        end
    end

    initial begin
        int          mix;
        int          i;
        tow_result_t none;
        none = '0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed dates, run with the reset offset of 18
        date_cases.push_back(date_case(1980, 1, 6, 0, 0, 0, 1, 18, 0));
        date_cases.push_back(date_case(1980, 1, 5, 23, 59, 59, 1, 0, 1));
        date_cases.push_back(date_case(1979, 12, 31, 23, 59, 59, 1, 0, 1));
        date_cases.push_back(date_case(0, 0, 0, 0, 0, 0, 1, 0, 1));
        date_cases.push_back(date_case(1980, 1, 0, 0, 0, 0, 1, 0, 1));
        date_cases.push_back(date_case(1980, 1, 12, 23, 59, 60, 1, 604818, 0));
        date_cases.push_back(date_case(1980, 1, 13, 0, 0, 0, 1, 18, 0));
        date_cases.push_back(date_case(1980, 0, 6, 0, 0, 0, 1, 18, 0));
        date_cases.push_back(date_case(1980, 1, 6, 31, 63, 63, 1, 115461, 0));
        date_cases.push_back(date_case(1980, 15, 31, 12, 30, 30, 0, 0, 0));
        date_cases.push_back(date_case(4095, 15, 31, 31, 63, 63, 0, 0, 0));
        date_cases.push_back(date_case(2235, 12, 31, 23, 59, 60, 0, 0, 0));
        date_cases.push_back(date_case(2000, 2, 29, 12, 0, 0, 0, 0, 0));
        date_cases.push_back(date_case(2000, 3, 1, 0, 0, 0, 0, 0, 0));
        date_cases.push_back(date_case(2100, 3, 1, 0, 0, 0, 0, 0, 0));
        date_cases.push_back(date_case(2400, 3, 1, 0, 0, 0, 0, 0, 0));
        date_cases.push_back(date_case(2024, 2, 30, 6, 7, 8, 0, 0, 0));
        date_cases.push_back(date_case(2024, 3, 0, 18, 45, 0, 0, 0, 0));
        date_cases.push_back(date_case(2048, 8, 16, 16, 32, 32, 0, 0, 0));
        date_cases.push_back(date_case(3000, 7, 4, 10, 20, 30, 0, 0, 0));
        date_cases.push_back(date_case(1980, 2, 1, 1, 1, 1, 0, 0, 0));
        foreach (date_cases[n])
            send_date(date_cases[n].req, date_cases[n].typed, date_cases[n].res);

        // Random requests: each mix of idling gets its own leap offset
        for (mix = 0; mix < 4; mix++) begin
            drain_results();
            case (mix)
                0: begin
                    write_leap_offset(8'd0);
                    sender_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    write_leap_offset(8'd255);
                    sender_idle_pct = 64;
                    recv_stall_pct = 0;
                end
                2: begin
                    write_leap_offset(8'($urandom_range(1, 254)));
                    sender_idle_pct = 0;
                    recv_stall_pct = 64;
                end
                default: begin
                    write_leap_offset(ugsow_pkg::LEAP_RESET);
                    sender_idle_pct = 23;
                    recv_stall_pct = 23;
                end
            endcase
            for (i = 0; i < ITEMS_PER_MIX; i++) begin
                if ($urandom_range(49) == 0)
                    drain_results();
                send_date(random_utc(), 1'b0, none);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Converted %0d dates (%0d before the epoch), offsets 18, 0, 255 and random,",
                 checked_count, pre_epoch_count);
        $display("with sender gaps and receiver back pressure mixed in.");
        if (err_count == 0 && pending_tow.size() == 0)
            $display("utc_to_gps_second_of_week_tb passed");
        else
            $display("utc_to_gps_second_of_week_tb failed");
        $finish;
    end

endmodule
